// ===== rtl/dptt_pkg.sv =====
// Shared types, constants and helpers for the depth-preferred transposition table.
// No dependencies; every other file of the block imports this package.
package dptt_pkg;

    // Default of the table size.
    localparam int DEF_INDEX_BITS = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] MATE_THR_RESET  = 15'd9000;
    localparam logic [CFG_DATA_W-1:0] WIN_LIMIT_RESET = 15'd10000;

    // Depth written by a clear.
    localparam logic [7:0] CLEARED_DEPTH = 8'hFF;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_op                op;
        logic               side;
        logic [63:0]        lock;
        logic signed [7:0]  depth;
        logic [7:0]         ply;
        logic signed [15:0] beta;
        logic signed [15:0] st_score;  // store score, already adjusted for mate
        logic               st_oob;    // store score beyond the win limit
        logic [15:0]        move;
    } t_cmd;

    // Clamp an 18-bit signed value to the 16-bit score range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/dptt_front.sv =====
// Front end of the transposition table: accepts items, classifies them and
// queues them for the back end. Depends on dptt_pkg.
module dptt_front
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_opcode,
    input  logic                   i_side,
    input  logic [31:0]            i_hash_key,
    input  logic [63:0]            i_check_lock,
    input  logic signed [7:0]      i_search_depth,
    input  logic [7:0]             i_ply_count,
    input  logic signed [15:0]     i_beta_bound,
    input  logic signed [15:0]     i_store_score,
    input  logic [15:0]            i_store_move,
    input  logic [CFG_DATA_W-1:0]  i_mate_thr,
    input  logic [CFG_DATA_W-1:0]  i_win_limit,
    input  logic                   i_init_busy,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_ready,
    output t_cmd                   o_cmd,
    output logic [INDEX_BITS-1:0]  o_idx
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd                  r_q   [QUEUE_DEPTH];
    logic [INDEX_BITS-1:0] r_qi  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr, r_rd;
    logic [CNT_W-1:0]      r_cnt;

    logic signed [16:0] s17, thr17, win17;
    logic signed [17:0] s18, ply18;
    logic signed [15:0] adj_score;
    logic               oob;
    t_cmd               cmd;
    logic               push, pop;

    // Classify the store score: bounds check against the win limit and the
    // mate adjustment by ply are done here, off the memory path.
    assign s17   = $signed({i_store_score[15], i_store_score});
    assign s18   = $signed({{2{i_store_score[15]}}, i_store_score});
    assign thr17 = $signed({2'b00, i_mate_thr});
    assign win17 = $signed({2'b00, i_win_limit});
    assign ply18 = $signed({10'd0, i_ply_count});
    assign oob   = (s17 > win17) || (s17 < -win17);

    always_comb begin
        if (s17 > thr17) begin
            adj_score = sat16(s18 + ply18);
        end else if (s17 < -thr17) begin
            adj_score = sat16(s18 - ply18);
        end else begin
            adj_score = i_store_score;
        end
    end

    always_comb begin
        cmd.op       = t_op'(i_opcode);
        cmd.side     = i_side;
        cmd.lock     = i_check_lock;
        cmd.depth    = i_search_depth;
        cmd.ply      = i_ply_count;
        cmd.beta     = i_beta_bound;
        cmd.st_score = adj_score;
        cmd.st_oob   = oob;
        cmd.move     = i_store_move;
    end

    assign o_in_ready  = (r_cnt != CNT_W'(QUEUE_DEPTH)) && !i_init_busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign o_idx       = r_qi[r_rd];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_ready && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr]  <= cmd;
            r_qi[r_wr] <= i_hash_key[INDEX_BITS-1:0];
        end
    end

endmodule

// ===== rtl/dptt_back.sv =====
// Back end of the transposition table: table memories, the sequencer that
// runs probes, stores, clears and the reset pass, and the result register.
// Depends on dptt_pkg.
module dptt_back
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  t_cmd                   i_cmd,
    input  logic [INDEX_BITS-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0]  i_mate_thr,
    output logic                   o_init_busy,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_score_valid,
    output logic signed [15:0]     o_result_score,
    output logic [15:0]            o_result_move
);

    localparam int AW    = INDEX_BITS + 1;   // bank bit on top of the index
    localparam int DEPTH = 1 << AW;
    localparam int DW    = 96;               // lock, score, move

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    // Memories.
    logic          r_valid_mem [DEPTH];
    logic [7:0]    r_depth_mem [DEPTH];
    logic [DW-1:0] r_data_mem  [DEPTH];

    logic          r_rd_valid;
    logic [7:0]    r_rd_depth;
    logic [DW-1:0] r_rd_data;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [AW-1:0]      r_sweep, n_sweep;
    t_cmd               r_cmd, n_cmd;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_out_valid, n_out_valid;
    logic               r_score_valid, n_score_valid;
    logic signed [15:0] r_score, n_score;
    logic [15:0]        r_move, n_move;

    logic [AW-1:0]      rd_addr;
    logic               go;
    logic               sweep_last;

    // Entry fields as read.
    logic [63:0]        ent_lock;
    logic signed [15:0] ent_score;
    logic [15:0]        ent_move;
    logic signed [7:0]  ent_depth;

    logic signed [16:0] s17, thr17;
    logic signed [17:0] s18, ply18;
    logic signed [15:0] low_adj;
    logic               hit, skip, store_wr;
    logic               probe_valid;
    logic signed [15:0] probe_score;

    logic               valid_we, valid_wd, depth_we, data_we;
    logic [AW-1:0]      valid_wa, depth_wa;
    logic [7:0]         depth_wd;

    assign rd_addr    = {i_cmd.side, i_idx};
    assign sweep_last = (r_sweep == {AW{1'b1}});
    assign go         = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_out_ready);

    assign o_cmd_ready = go;
    assign o_init_busy = (r_state == S_INIT);

    assign {ent_lock, ent_score, ent_move} = r_rd_data;
    assign ent_depth = $signed(r_rd_depth);

    // Probe evaluation on the registered read data.
    assign s17   = $signed({ent_score[15], ent_score});
    assign s18   = $signed({{2{ent_score[15]}}, ent_score});
    assign thr17 = $signed({2'b00, i_mate_thr});
    assign ply18 = $signed({10'd0, r_cmd.ply});
    assign hit   = r_rd_valid && (ent_lock == r_cmd.lock);

    assign low_adj = (s17 < -thr17) ? sat16(s18 + ply18) : ent_score;

    always_comb begin
        probe_valid = 1'b0;
        probe_score = '0;
        if (hit) begin
            if (s17 > thr17) begin
                probe_valid = 1'b1;
                probe_score = sat16(s18 - ply18);
            end else if ((ent_depth >= r_cmd.depth) && (low_adj >= r_cmd.beta)) begin
                probe_valid = 1'b1;
                probe_score = low_adj;
            end
        end
    end

    // A store is dropped when out of bounds or when a deeper valid entry sits there.
    assign skip     = r_cmd.st_oob || (r_rd_valid && (ent_depth > r_cmd.depth));
    assign store_wr = (r_state == S_EXEC) && (r_cmd.op == OP_STORE) && !skip;

    assign valid_we = (r_state == S_INIT) || store_wr;
    assign valid_wa = (r_state == S_INIT) ? r_sweep : r_addr;
    assign valid_wd = (r_state != S_INIT);
    assign depth_we = (r_state == S_CLEAR) || store_wr;
    assign depth_wa = (r_state == S_CLEAR) ? r_sweep : r_addr;
    assign depth_wd = (r_state == S_CLEAR) ? CLEARED_DEPTH : r_cmd.depth;
    assign data_we  = store_wr;

    always_ff @(posedge i_clk) begin
        if (valid_we) begin
            r_valid_mem[valid_wa] <= valid_wd;
        end
        r_rd_valid <= r_valid_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            r_depth_mem[depth_wa] <= depth_wd;
        end
        r_rd_depth <= r_depth_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[r_addr] <= {r_cmd.lock, r_cmd.st_score, r_cmd.move};
        end
        r_rd_data <= r_data_mem[rd_addr];
    end

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_cmd         = r_cmd;
        n_addr        = r_addr;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_score_valid = r_score_valid;
        n_score       = r_score;
        n_move        = r_move;
        case (r_state)
            S_INIT: begin
                n_sweep = r_sweep + 1'b1;
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (go) begin
                    n_cmd   = i_cmd;
                    n_addr  = rd_addr;
                    n_sweep = '0;
                    n_state = (i_cmd.op == OP_CLEAR) ? S_CLEAR : S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid   = 1'b1;
                n_score_valid = 1'b0;
                n_score       = '0;
                n_move        = '0;
                if (r_cmd.op == OP_PROBE) begin
                    n_score_valid = probe_valid;
                    n_score       = probe_score;
                    n_move        = hit ? ent_move : 16'd0;
                end
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (sweep_last) begin
                    n_out_valid   = 1'b1;
                    n_score_valid = 1'b0;
                    n_score       = '0;
                    n_move        = '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_addr        <= n_addr;
        r_score_valid <= n_score_valid;
        r_score       <= n_score;
        r_move        <= n_move;
    end

    assign o_out_valid    = r_out_valid;
    assign o_score_valid  = r_score_valid;
    assign o_result_score = r_score;
    assign o_result_move  = r_move;

endmodule

// ===== rtl/depth_preferred_transposition_table_unit.sv =====
// Top level of the depth-preferred transposition table: configuration
// registers, front and back ends, and assertions.
// Depends on dptt_pkg, dptt_front and dptt_back.
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  ------------------------------------------
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   request   i_in_valid  / o_in_ready   i_opcode .. i_store_move
//   result    o_out_valid / i_out_ready  o_score_valid, o_result_score, o_result_move
//
// In the back end a probe, a store or an unused opcode runs in two steps: the
// entry is read from the table memories, then evaluated, and a store written back.
// A clear rewrites the depth memory one entry per cycle over both banks. After
// reset a clearing pass zeroes the valid marks; requests are refused during it,
// config writes are not. A two-item queue sits between the front and back ends,
// so requests are still accepted while a result waits to be taken; the back end
// starts a new item only when the result register is free or being emptied.
module depth_preferred_transposition_table_unit
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Requests
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_opcode,
    input  logic                   i_side,
    input  logic [31:0]            i_hash_key,
    input  logic [63:0]            i_check_lock,
    input  logic signed [7:0]      i_search_depth,
    input  logic [7:0]             i_ply_count,
    input  logic signed [15:0]     i_beta_bound,
    input  logic signed [15:0]     i_store_score,
    input  logic [15:0]            i_store_move,
    // Results
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_score_valid,
    output logic signed [15:0]     o_result_score,
    output logic [15:0]            o_result_move
);

    // Items in flight: queue, back end and result register together.
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;
    localparam int INF_W        = $clog2(MAX_INFLIGHT + 1);

    logic [CFG_DATA_W-1:0] r_mate_thr;
    logic [CFG_DATA_W-1:0] r_win_limit;

    logic                  cmd_valid;
    logic                  cmd_ready;
    t_cmd                  cmd;
    logic [INDEX_BITS-1:0] cmd_idx;
    logic                  init_busy;

    logic [INF_W-1:0]      r_inflight;
    logic                  in_fire, out_fire;

    // Configuration registers. Writes must arrive only while the block is idle; the
    // block does not enforce this itself, and the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_thr  <= MATE_THR_RESET;
            r_win_limit <= WIN_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MATE_THR:  r_mate_thr  <= i_cfg_data;
                CFG_WIN_LIMIT: r_win_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each request and queues it.
    dptt_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_side         (i_side),
        .i_hash_key     (i_hash_key),
        .i_check_lock   (i_check_lock),
        .i_search_depth (i_search_depth),
        .i_ply_count    (i_ply_count),
        .i_beta_bound   (i_beta_bound),
        .i_store_score  (i_store_score),
        .i_store_move   (i_store_move),
        .i_mate_thr     (r_mate_thr),
        .i_win_limit    (r_win_limit),
        .i_init_busy    (init_busy),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_ready    (cmd_ready),
        .o_cmd          (cmd),
        .o_idx          (cmd_idx)
    );

    // The back end owns the table and runs one item at a time.
    dptt_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_ready    (cmd_ready),
        .i_cmd          (cmd),
        .i_idx          (cmd_idx),
        .i_mate_thr     (r_mate_thr),
        .o_init_busy    (init_busy),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_score_valid  (o_score_valid),
        .o_result_score (o_result_score),
        .o_result_move  (o_result_move)
    );

    // Running count of accepted items whose result has not been taken yet.
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_fire && !out_fire) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_fire && !in_fire) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // Requests are refused in the first cycle out of reset: the clearing pass runs.
    a_init_blocks: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("request accepted before the reset clearing pass");

    // A result is never shown without an accepted item behind it.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_inflight != '0))
        else $error("result without an outstanding item");

    // The queue, back end and result register bound the items in flight.
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= INF_W'(MAX_INFLIGHT))
        else $error("more items in flight than the block can hold");

    // A queued item stays offered to the back end until the back end takes it.
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && !cmd_ready) |=> cmd_valid)
        else $error("queued item lost before the back end took it");

endmodule
